// ===== hw/rtl/bump_arena_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Bump arena allocator assertion macros
// Concurrent assertion shorthands; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BUMP_ARENA_ALLOCATOR_MACROS_SVH
`define BUMP_ARENA_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
`define BBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define BBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BBA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BBA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// Bump arena allocator package
// Action and register codes, request and configuration types.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam logic [2:0] ACT_PUSH      = 3'd0;
	localparam logic [2:0] ACT_PUSH_ZERO = 3'd1;
	localparam logic [2:0] ACT_POP       = 3'd2;
	localparam logic [2:0] ACT_CLEAR     = 3'd3;
	localparam logic [2:0] ACT_SAVE      = 3'd4;
	localparam logic [2:0] ACT_RESTORE   = 3'd5;

	localparam logic [1:0] CFG_ARENA  = 2'd0;
	localparam logic [1:0] CFG_HEADER = 2'd1;
	localparam logic [1:0] CFG_BASE   = 2'd2;

	localparam logic [31:0] ARENA_RST  = 32'd65536;
	localparam logic [12:0] HEADER_RST = 13'd64;
	localparam logic [31:0] BASE_RST   = 32'd0;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] need;
		logic [12:0] amask;
	} bba_req_t;

	typedef struct packed {
		logic [31:0] arena;
		logic [12:0] header;
		logic [31:0] base;
	} bba_cfg_t;

endpackage

// ===== hw/rtl/bump_arena_allocator.sv =====
// Throughput: one item per cycle while out_stall is low; size * count is formed in
// the input register, the offset fit check and state update sit between that and
// the result register.
// Reset: offsets and checkpoint return to 64, arena 65536, header 64, base 0.
// ----------------------------------------------------------------------------
// Bump arena allocator top level
// Configuration registers and the two-stage request pipeline.
// ----------------------------------------------------------------------------
module bump_arena_allocator import bba_pkg::*; #(
	parameter int ADDR_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [15:0] elem_size,
	input  logic [12:0] align,
	input  logic [15:0] elem_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] address,
	output logic        status,
	output logic        zero_fill,
	output logic [31:0] offset_now
);

	bba_cfg_t cfg_q;
	bba_req_t req_s1;
	logic     valid_s1;
	logic     exec_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arena  <= ARENA_RST;
			cfg_q.header <= HEADER_RST;
			cfg_q.base   <= BASE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ARENA:  cfg_q.arena  <= cfg_data;
				CFG_HEADER: cfg_q.header <= cfg_data[12:0];
				CFG_BASE:   cfg_q.base   <= cfg_data;
				default: ;
			endcase
		end
	end

	bba_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.elem_size  (elem_size),
		.align      (align),
		.elem_count (elem_count),
		.exec_ready (exec_ready),
		.valid_s1   (valid_s1),
		.req_s1     (req_s1)
	);

	bba_exec #(
		.ADDR_BITS (ADDR_BITS)
	) u_exec (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.req_s1     (req_s1),
		.exec_ready (exec_ready),
		.cfg        (cfg_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.address    (address),
		.status     (status),
		.zero_fill  (zero_fill),
		.offset_now (offset_now)
	);

endmodule

// ===== hw/rtl/bba_in_stage.sv =====
// ----------------------------------------------------------------------------
// Bump arena allocator input stage
// Registers a request, forms size * count and the alignment mask.
// ----------------------------------------------------------------------------
module bba_in_stage import bba_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [15:0] elem_size,
	input  logic [12:0] align,
	input  logic [15:0] elem_count,
	input  logic        exec_ready,
	output logic        valid_s1,
	output bba_req_t    req_s1
);

	logic        take;
	logic [12:0] align_eff;

	assign take      = !valid_s1 || exec_ready;
	assign in_stall  = !take;
	assign align_eff = (align == 13'd0) ? 13'd1 : align;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_valid) begin
			req_s1.action <= action;
			req_s1.need   <= elem_size * elem_count;
			req_s1.amask  <= align_eff - 13'd1;
		end
	end

endmodule

// ===== hw/rtl/bba_exec.sv =====
// ----------------------------------------------------------------------------
// Bump arena allocator execute stage
// Offset state, fit checks and the result register.
// ----------------------------------------------------------------------------
`include "bump_arena_allocator_macros.svh"

module bba_exec import bba_pkg::*; #(
	parameter int ADDR_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s1,
	input  bba_req_t    req_s1,
	output logic        exec_ready,
	input  bba_cfg_t    cfg,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] address,
	output logic        status,
	output logic        zero_fill,
	output logic [31:0] offset_now
);

	localparam logic [31:0] AddrMask = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << ADDR_BITS) - 64'd1);

	logic [31:0] cur_q, last_q, ckpt_q, ckpt_last_q;
	logic [31:0] cur_d, last_d, ckpt_d, ckpt_last_d;
	logic        fire;
	logic [12:0] pad;
	logic [31:0] cur_pad;
	logic [33:0] push_sum;
	logic [32:0] pop_take;
	logic [31:0] hdr32;
	logic [31:0] pop_room;
	logic [31:0] pop_new;
	logic        push_fail, pop_fail;
	logic [31:0] blk_off;
	logic [31:0] addr_d;
	logic        fail_d, zf_d, has_addr;

	assign exec_ready = !out_valid || !out_stall;
	assign fire       = valid_s1 && exec_ready;

	assign hdr32    = {19'd0, cfg.header};
	assign pad      = (~cur_q[12:0] + 13'd1) & req_s1.amask;
	assign cur_pad  = cur_q + {19'd0, pad};
	assign push_sum = {2'b00, cur_q} + {21'd0, pad} + {2'b00, req_s1.need};
	assign push_fail = push_sum > {2'b00, cfg.arena};
	assign pop_take = {20'd0, pad} + {1'b0, req_s1.need};
	assign pop_room = cur_q - hdr32;
	assign pop_fail = (cur_q < hdr32) || (pop_take > {1'b0, pop_room});
	assign pop_new  = cur_q - {19'd0, pad} - req_s1.need;

	always_comb begin
		cur_d       = cur_q;
		last_d      = last_q;
		ckpt_d      = ckpt_q;
		ckpt_last_d = ckpt_last_q;
		fail_d      = 1'b0;
		zf_d        = 1'b0;
		has_addr    = 1'b0;
		blk_off     = cur_pad;
		unique case (req_s1.action)
			ACT_PUSH, ACT_PUSH_ZERO: begin
				if (push_fail) begin
					fail_d = 1'b1;
				end else begin
					has_addr = 1'b1;
					last_d   = cur_q;
					cur_d    = push_sum[31:0];
					zf_d     = (req_s1.action == ACT_PUSH_ZERO);
				end
			end
			ACT_POP: begin
				blk_off = pop_new;
				if (pop_fail) begin
					fail_d = 1'b1;
				end else begin
					has_addr = 1'b1;
					last_d   = cur_q;
					cur_d    = pop_new;
				end
			end
			ACT_CLEAR: begin
				last_d = cur_q;
				cur_d  = hdr32;
			end
			ACT_SAVE: begin
				ckpt_d      = cur_q;
				ckpt_last_d = last_q;
			end
			ACT_RESTORE: begin
				cur_d  = ckpt_q;
				last_d = ckpt_last_q;
			end
			default: begin
				fail_d = 1'b1;
			end
		endcase
		addr_d = has_addr ? ((cfg.base + blk_off) & AddrMask) : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= {19'd0, HEADER_RST};
			last_q      <= {19'd0, HEADER_RST};
			ckpt_q      <= {19'd0, HEADER_RST};
			ckpt_last_q <= {19'd0, HEADER_RST};
			out_valid   <= 1'b0;
		end else begin
			if (exec_ready) begin
				out_valid <= valid_s1;
			end
			if (fire) begin
				cur_q       <= cur_d;
				last_q      <= last_d;
				ckpt_q      <= ckpt_d;
				ckpt_last_q <= ckpt_last_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			address    <= addr_d;
			status     <= fail_d;
			zero_fill  <= zf_d;
			offset_now <= cur_d;
		end
	end

	`BBA_ASSERT_IMP(a_zf_ok, clk, arst_n, out_valid && zero_fill, !status)
	`BBA_ASSERT_NXT(a_fail_hold, clk, arst_n, fire && fail_d, $stable(cur_q) && $stable(last_q))
	`BBA_ASSERT_NXT(a_push_fits, clk, arst_n, fire && has_addr && (req_s1.action != ACT_POP), cur_q <= $past(cfg.arena))
	`BBA_ASSERT_NXT(a_result_cur, clk, arst_n, fire, offset_now == cur_q)

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bump arena allocator testbench
// Drives allocate, free, clear, checkpoint and unused-action requests under random input
// gaps and output stalls. Every result is checked against an in-bench
// allocator model, across several arena, header and base settings.
// ----------------------------------------------------------------------------
module tb;
	import bba_pkg::*;

	localparam logic [2:0] ACT_UNUSED6 = 3'd6;
	localparam logic [2:0] ACT_UNUSED7 = 3'd7;

	typedef struct {
		logic [2:0]  action;
		logic [15:0] size;
		logic [12:0] align;
		logic [15:0] count;
	} alloc_req_t;

	typedef struct {
		logic [31:0] address;
		logic        status;
		logic        zero_fill;
		logic [31:0] offset_now;
	} alloc_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_ARENA;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  action = ACT_PUSH;
	logic [15:0] elem_size = '0;
	logic [12:0] align = '0;
	logic [15:0] elem_count = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] address;
	logic        status;
	logic        zero_fill;
	logic [31:0] offset_now;

	// allocator model state
	logic [31:0] off_cur, off_prev, mark_cur, mark_prev;
	logic [31:0] arena_size, base_addr;
	logic [12:0] header_size;

	alloc_result_t grant_q[$];
	int error_count = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int reg_writes = 0;
	int settings_used = 1;
	bit quiet = 1'b0;
	int send_calm = 0;

	bump_arena_allocator i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .elem_size(elem_size), .align(align), .elem_count(elem_count),
		.out_valid(out_valid), .out_stall(out_stall),
		.address(address), .status(status), .zero_fill(zero_fill), .offset_now(offset_now)
	);

	always #10 clk = ~clk;

	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic report(input string msg);
		$display("MISMATCH: %s", msg);
		error_count++;
	endtask

	function automatic alloc_result_t arena_step(input alloc_req_t r);
		alloc_result_t res;
		logic [63:0] need, pad, amask, cur64, hdr64, nv;
		res = '{address: '0, status: 1'b0, zero_fill: 1'b0, offset_now: '0};
		need = 64'(r.size) * 64'(r.count);
		amask = (r.align == 13'd0) ? 64'd0 : 64'(r.align) - 64'd1;
		cur64 = 64'(off_cur);
		hdr64 = 64'(header_size);
		pad = (64'd0 - cur64) & amask;
		case (r.action)
			ACT_PUSH, ACT_PUSH_ZERO: begin
				if (cur64 + pad + need > 64'(arena_size)) begin
					res.status = 1'b1;
				end else begin
					res.address = base_addr + 32'(cur64 + pad);
					off_prev = off_cur;
					off_cur = 32'(cur64 + pad + need);
					res.zero_fill = (r.action == ACT_PUSH_ZERO);
				end
			end
			ACT_POP: begin
				if (cur64 < hdr64 || pad + need > cur64 - hdr64) begin
					res.status = 1'b1;
				end else begin
					nv = cur64 - pad - need;
					res.address = base_addr + 32'(nv);
					off_prev = off_cur;
					off_cur = 32'(nv);
				end
			end
			ACT_CLEAR: begin
				off_prev = off_cur;
				off_cur = 32'(header_size);
			end
			ACT_SAVE: begin
				mark_cur = off_cur;
				mark_prev = off_prev;
			end
			ACT_RESTORE: begin
				off_cur = mark_cur;
				off_prev = mark_prev;
			end
			default: res.status = 1'b1;
		endcase
		res.offset_now = off_cur;
		return res;
	endfunction

	// one request transfer; valid stays high afterwards so back-to-back items never toggle it
	task automatic send_item(input alloc_req_t r);
		if (!quiet) begin
			if (send_calm > 0) begin
				send_calm--;
			end else if ($urandom_range(0, 39) == 0) begin
				send_calm = $urandom_range(20, 60);
			end else if ($urandom_range(0, 3) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		action <= r.action;
		elem_size <= r.size;
		align <= r.align;
		elem_count <= r.count;
		do @(posedge clk); while (in_stall);
		grant_q.push_back(arena_step(r));
		requests_sent++;
	endtask

	task automatic send_req(input logic [2:0] act, input logic [15:0] size,
			input logic [12:0] algn, input logic [15:0] count);
		alloc_req_t r;
		r = '{action: act, size: size, align: algn, count: count};
		send_item(r);
	endtask

	task automatic wait_for_idle();
		in_valid <= 1'b0;
		while (grant_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_ARENA:  arena_size = data;
			CFG_HEADER: header_size = data[12:0];
			CFG_BASE:   base_addr = data;
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic set_config(input logic [31:0] arena, input logic [12:0] header,
			input logic [31:0] base);
		wait_for_idle();
		write_reg(CFG_ARENA, arena);
		write_reg(CFG_HEADER, {19'd0, header});
		write_reg(CFG_BASE, base);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	function automatic alloc_req_t random_request();
		alloc_req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30) r.action = ACT_PUSH;
		else if (pick < 45) r.action = ACT_PUSH_ZERO;
		else if (pick < 70) r.action = ACT_POP;
		else if (pick < 76) r.action = ACT_CLEAR;
		else if (pick < 84) r.action = ACT_SAVE;
		else if (pick < 93) r.action = ACT_RESTORE;
		else r.action = $urandom_range(0, 1) ? ACT_UNUSED6 : ACT_UNUSED7;
		case ($urandom_range(0, 9))
			0: r.size = 16'($urandom);
			1: r.size = 16'd0;
			default: r.size = 16'($urandom_range(1, 64));
		endcase
		case ($urandom_range(0, 9))
			0: r.count = 16'($urandom);
			1: r.count = 16'd0;
			default: r.count = 16'($urandom_range(1, 16));
		endcase
		case ($urandom_range(0, 9))
			0: r.align = 13'd0;
			1: r.align = 13'($urandom);
			default: r.align = 13'd1 << $urandom_range(0, 12);
		endcase
		return r;
	endfunction

	task automatic test_directed_ops();
		send_req(ACT_PUSH, 16'd16, 13'd8, 16'd4);
		send_req(ACT_PUSH_ZERO, 16'd1, 13'd1, 16'd3);
		send_req(ACT_PUSH, 16'd8, 13'd0, 16'd1);
		send_req(ACT_PUSH, 16'd4, 13'd4096, 16'd2);
		send_req(ACT_PUSH, 16'd1, 13'd3, 16'd1);
		send_req(ACT_PUSH, 16'hFFFF, 13'd1, 16'hFFFF);
		send_req(ACT_PUSH, 16'd0, 13'd2, 16'd100);
		send_req(ACT_PUSH_ZERO, 16'd5, 13'd16, 16'd0);
		send_req(ACT_SAVE, 16'd0, 13'd0, 16'd0);
		send_req(ACT_PUSH, 16'd100, 13'd16, 16'd10);
		send_req(ACT_POP, 16'd100, 13'd16, 16'd10);
		send_req(ACT_RESTORE, 16'd0, 13'd0, 16'd0);
		send_req(ACT_POP, 16'hFFFF, 13'h1FFF, 16'hFFFF);
		send_req(ACT_CLEAR, 16'd0, 13'd0, 16'd0);
		send_req(ACT_POP, 16'd1, 13'd1, 16'd1);
		send_req(ACT_POP, 16'd0, 13'd1, 16'd0);
		send_req(ACT_UNUSED6, 16'hFFFF, 13'h1FFF, 16'hFFFF);
		send_req(ACT_UNUSED7, 16'd1, 13'd1, 16'd1);
		send_req(ACT_PUSH_ZERO, 16'hFFFF, 13'd4096, 16'd1);
		send_req(ACT_PUSH_ZERO, 16'd255, 13'd64, 16'd200);
		send_req(ACT_RESTORE, 16'd0, 13'd0, 16'd0);
	endtask

	task automatic test_random_ops(input int n);
		repeat (n) send_item(random_request());
	endtask

	// burst, then hold off until every result is back, then another burst
	task automatic test_drain_pause();
		repeat (20) send_item(random_request());
		wait_for_idle();
		repeat (20) send_item(random_request());
	endtask

	// output stall: random bursts with occasional calm stretches
	int stall_left = 0;
	int stall_calm = 0;
	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (stall_calm > 0) begin
			stall_calm--;
			out_stall <= 1'b0;
		end else if ($urandom_range(0, 49) == 0) begin
			stall_calm = $urandom_range(30, 80);
			out_stall <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 16) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (grant_q.size() == 0) begin
				report($sformatf("result with nothing pending: address %h offset %h",
					address, offset_now));
			end else begin
				want = grant_q.pop_front();
				results_checked++;
				if (address !== want.address)
					report($sformatf("result %0d address: expected %h got %h",
						results_checked, want.address, address));
				if (status !== want.status)
					report($sformatf("result %0d status: expected %b got %b",
						results_checked, want.status, status));
				if (zero_fill !== want.zero_fill)
					report($sformatf("result %0d zero_fill: expected %b got %b",
						results_checked, want.zero_fill, zero_fill));
				if (offset_now !== want.offset_now)
					report($sformatf("result %0d offset_now: expected %h got %h",
						results_checked, want.offset_now, offset_now));
			end
		end
	end

	initial begin
		arena_size = ARENA_RST;
		header_size = HEADER_RST;
		base_addr = BASE_RST;
		off_cur = 32'(HEADER_RST);
		off_prev = 32'(HEADER_RST);
		mark_cur = 32'(HEADER_RST);
		mark_prev = 32'(HEADER_RST);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_ops();
		test_random_ops(300);
		set_config(32'd1, 13'd0, 32'hFFFF_FFFF);
		test_random_ops(150);
		set_config(32'hFFFF_FFFF, 13'd4096, 32'hFFFF_F000);
		test_random_ops(300);
		set_config(32'd0, 13'h1FFF, 32'h8000_0000);
		test_random_ops(100);
		set_config(32'd20000, 13'd100, 32'h1234_5678);
		test_drain_pause();
		test_random_ops(250);
		quiet = 1'b1;
		set_config(ARENA_RST, HEADER_RST, BASE_RST);
		test_random_ops(400);

		wait_for_idle();
		repeat (4) @(posedge clk);
		if (grant_q.size() != 0)
			report($sformatf("%0d results never arrived", grant_q.size()));
		$display("Summary: %0d requests, %0d results checked, %0d register writes, %0d settings",
			requests_sent, results_checked, reg_writes, settings_used);
		$display("Summary: push, zeroed push, pop, clear, checkpoint, unused actions, arena extremes");
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/bba_pkg.sv
hw/rtl/bba_in_stage.sv
hw/rtl/bba_exec.sv
hw/rtl/bump_arena_allocator.sv
test/tb.sv
